FILE: sv/pcs_pkg.sv
`timescale 1ns / 1ps

package pcs_pkg;

	// quarter-wave sine table
	localparam int SINE_TABLE_BITS = 8;
	localparam int SINE_N = 1 << SINE_TABLE_BITS;
	localparam int SINE_ADDR_W = SINE_TABLE_BITS + 1;
	localparam logic [SINE_ADDR_W-1:0] SINE_LAST = SINE_ADDR_W'(SINE_N);

	localparam longint PI_HALF_Q30 = 64'sd1686629713;
	localparam longint Q30 = 64'sd1073741824;

	typedef logic [15:0] sine_rom_t [0:SINE_N];

	// integer taylor series in q30, rounded to q1.15
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint v;
		for (int i = 0; i <= SINE_N; i++) begin
			x = (PI_HALF_Q30 * longint'(i)) / SINE_N;
			x2 = (x * x) / Q30;
			term = x;
			sum = x;
			// odd terms up to x^17, divisor (2n)(2n+1) for n = 1..8
			term = -((term * x2) / Q30) / 6;
			sum = sum + term;
			term = -((term * x2) / Q30) / 20;
			sum = sum + term;
			term = -((term * x2) / Q30) / 42;
			sum = sum + term;
			term = -((term * x2) / Q30) / 72;
			sum = sum + term;
			term = -((term * x2) / Q30) / 110;
			sum = sum + term;
			term = -((term * x2) / Q30) / 156;
			sum = sum + term;
			term = -((term * x2) / Q30) / 210;
			sum = sum + term;
			term = -((term * x2) / Q30) / 272;
			sum = sum + term;
			if (sum < 0) begin
				sum = 0;
			end
			v = (sum * 32767 + (Q30 / 2)) / Q30;
			if (v > 32767) begin
				v = 32767;
			end
			rom[i] = v[15:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// seed scramble and noise generator
	localparam logic [31:0] SCRAMBLE_MUL = 32'd2654435761;
	localparam logic [31:0] SCRAMBLE_ADD = 32'd12345;
	localparam logic [31:0] LCG_MUL = 32'd1664525;
	localparam logic [31:0] LCG_ADD = 32'd1013904223;

	localparam logic [23:0] ENV_ONE = 24'h800000;

	// jitter depths in q0.24
	localparam logic [20:0] JIT_VOL = 21'd1342177;
	localparam logic [20:0] JIT_PING = 21'd503316;
	localparam logic [20:0] JIT_RING = 21'd1006633;

	// configuration register file
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLICK_LENGTH = 3'd0,
		REG_PING_STEP    = 3'd1,
		REG_RING_RATE    = 3'd2,
		REG_NOISE_RATE   = 3'd3,
		REG_VOLUME       = 3'd4,
		REG_NOISE_MIX    = 3'd5,
		REG_BODY_MIX     = 3'd6
	} reg_idx_t;

	localparam logic [15:0] RST_CLICK_LENGTH = 16'd2640;
	localparam logic [31:0] RST_PING_STEP = 32'd62634940;
	localparam logic [23:0] RST_RING_RATE = 24'd62915;
	localparam logic [23:0] RST_NOISE_RATE = 24'd139231;
	localparam logic [15:0] RST_VOLUME = 16'd19661;
	localparam logic [15:0] RST_NOISE_MIX = 16'd45875;
	localparam logic [15:0] RST_BODY_MIX = 16'd39322;

	typedef struct packed {
		logic [15:0] click_length;
		logic [31:0] ping_step;
		logic [23:0] ring_rate;
		logic [23:0] noise_rate;
		logic [15:0] volume;
		logic [15:0] noise_mix;
		logic [15:0] body_mix;
	} cfg_t;

	// which value the current random draw feeds
	typedef enum logic [1:0] {
		J_VOL   = 2'd0,
		J_PING  = 2'd1,
		J_RING  = 2'd2,
		J_NOISE = 2'd3
	} jsel_t;

	typedef enum logic [21:0] {
		S_IDLE     = 22'h000001,
		S_SEED_ADD = 22'h000002,
		S_LCG_MUL  = 22'h000004,
		S_LCG_ADD  = 22'h000008,
		S_RMAG     = 22'h000010,
		S_JF_MUL   = 22'h000020,
		S_JD_MUL   = 22'h000040,
		S_JAPPLY   = 22'h000080,
		S_START    = 22'h000100,
		S_CHECK    = 22'h000200,
		S_NT_MUL   = 22'h000400,
		S_BT_MUL   = 22'h000800,
		S_NM_MUL   = 22'h001000,
		S_BM_MUL   = 22'h002000,
		S_MIX      = 22'h004000,
		S_MABS     = 22'h008000,
		S_G_MUL    = 22'h010000,
		S_SAT      = 22'h020000,
		S_NE_MUL   = 22'h040000,
		S_RE_MUL   = 22'h080000,
		S_UPD      = 22'h100000,
		S_EMIT     = 22'h200000
	} state_t;

endpackage

FILE: sv/pcs_mul.sv
`timescale 1ns / 1ps

module pcs_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= {32'd0, a} * {32'd0, b};
	end

endmodule

FILE: sv/pcs_cfg.sv
`timescale 1ns / 1ps

module pcs_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wen,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]    index,
	input  logic [pcs_pkg::CFG_DATA_W-1:0]   data,
	output pcs_pkg::cfg_t                    cfg
);

	pcs_pkg::cfg_t regs_q;

	assign cfg = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.click_length <= pcs_pkg::RST_CLICK_LENGTH;
			regs_q.ping_step <= pcs_pkg::RST_PING_STEP;
			regs_q.ring_rate <= pcs_pkg::RST_RING_RATE;
			regs_q.noise_rate <= pcs_pkg::RST_NOISE_RATE;
			regs_q.volume <= pcs_pkg::RST_VOLUME;
			regs_q.noise_mix <= pcs_pkg::RST_NOISE_MIX;
			regs_q.body_mix <= pcs_pkg::RST_BODY_MIX;
		end else if (wen) begin
			case (index)
				pcs_pkg::REG_CLICK_LENGTH: regs_q.click_length <= data[15:0];
				pcs_pkg::REG_PING_STEP:    regs_q.ping_step <= data[31:0];
				pcs_pkg::REG_RING_RATE:    regs_q.ring_rate <= data[23:0];
				pcs_pkg::REG_NOISE_RATE:   regs_q.noise_rate <= data[23:0];
				pcs_pkg::REG_VOLUME:       regs_q.volume <= data[15:0];
				pcs_pkg::REG_NOISE_MIX:    regs_q.noise_mix <= data[15:0];
				pcs_pkg::REG_BODY_MIX:     regs_q.body_mix <= data[15:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/percussive_click_synth.sv
`timescale 1ns / 1ps
// one item in flight at a time, all math on one shared 32x32 multiplier
// idle tick: check goes straight to emit, and the next beat is taken once the emit step ends
// tick inside a click: one noise draw, then the mix, gain, saturate and envelope steps before emit
// strike: scramble and three jitter draws first, then the click starts and runs as a tick
// a stalled output holds the emit step; the output register frees the input side
// arst_n clears the voice state and loads the register defaults; no clearing pass

module percussive_click_synth (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           kind,
	input  logic [31:0]                    seed,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [15:0]             sample,
	output logic                           active,
	input  logic                           cfg_wen,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcs_pkg::CFG_DATA_W-1:0] cfg_data
);

	pcs_pkg::cfg_t   cfg;
	pcs_pkg::state_t state_q;
	pcs_pkg::jsel_t  jsel_q;

	// voice state
	logic [31:0] noise_q;
	logic [31:0] phase_q;
	logic [15:0] count_q;
	logic [23:0] nenv_q;
	logic [23:0] renv_q;
	logic [16:0] gain_q;
	logic [31:0] step_q;
	logic [23:0] decay_q;
	logic        sounding_q;

	// working registers
	logic [23:0] rmag_q;
	logic        rneg_q;
	logic [14:0] sine_mag_q;
	logic        sine_neg_q;
	logic [23:0] nterm_q;
	logic [23:0] bterm_q;
	logic [39:0] p1_q;
	logic [41:0] sum_q;
	logic [24:0] mixmag_q;
	logic        mixneg_q;
	logic [15:0] res_sample_q;
	logic        res_active_q;

	// output register
	logic        out_valid_q;
	logic [15:0] sample_q;
	logic        active_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod_q;

	logic [31:0] noise_next;
	logic [23:0] rmag_next;
	logic [pcs_pkg::SINE_TABLE_BITS-1:0] sine_idx;
	logic [pcs_pkg::SINE_ADDR_W-1:0] sine_addr;
	logic [15:0] sine_val;
	logic [31:0] jbase;
	logic [20:0] jk;
	logic [31:0] jdelta;
	logic [32:0] jsum;
	logic [41:0] t1;
	logic [41:0] t2;
	logic [41:0] sum_abs;
	logic [17:0] smag;
	logic [17:0] sneg;
	logic [15:0] sat_val;
	logic [15:0] count_inc;
	logic        accept_in;
	logic        out_free;

	pcs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	pcs_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign in_stall = (state_q != pcs_pkg::S_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign sample = sample_q;
	assign active = active_q;

	// datapath helpers
	assign noise_next = prod_q[31:0] + pcs_pkg::LCG_ADD;
	assign rmag_next = noise_q[31] ? {1'b0, noise_q[30:8]} :
		pcs_pkg::ENV_ONE - {1'b0, noise_q[30:8]};

	assign sine_idx = phase_q[29 -: pcs_pkg::SINE_TABLE_BITS];
	assign sine_addr = phase_q[30] ? pcs_pkg::SINE_LAST - {1'b0, sine_idx} : {1'b0, sine_idx};
	assign sine_val = pcs_pkg::SINE_ROM[sine_addr];

	assign jdelta = prod_q[55:24];
	assign jsum = rneg_q ? {1'b0, jbase} - {1'b0, jdelta} : {1'b0, jbase} + {1'b0, jdelta};

	assign t1 = rneg_q ? 42'd0 - {2'b0, p1_q} : {2'b0, p1_q};
	assign t2 = sine_neg_q ? 42'd0 - {2'b0, prod_q[39:0]} : {2'b0, prod_q[39:0]};
	assign sum_abs = sum_q[41] ? 42'd0 - sum_q : sum_q;

	assign smag = prod_q[41:24];
	assign sneg = 18'd0 - smag;
	assign count_inc = count_q + 16'd1;

	always_comb begin
		if (mixneg_q) begin
			sat_val = (smag > 18'd32768) ? 16'h8000 : sneg[15:0];
		end else begin
			sat_val = (smag > 18'd32767) ? 16'h7FFF : smag[15:0];
		end
	end

	always_comb begin
		case (jsel_q)
			pcs_pkg::J_VOL: begin
				jbase = {16'd0, cfg.volume};
				jk = pcs_pkg::JIT_VOL;
			end
			pcs_pkg::J_PING: begin
				jbase = cfg.ping_step;
				jk = pcs_pkg::JIT_PING;
			end
			pcs_pkg::J_RING: begin
				jbase = {8'd0, cfg.ring_rate};
				jk = pcs_pkg::JIT_RING;
			end
			default: begin
				jbase = '0;
				jk = '0;
			end
		endcase
	end

	// multiplier operands per step, product shows up in the following step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			pcs_pkg::S_IDLE: begin
				mul_a = seed;
				mul_b = pcs_pkg::SCRAMBLE_MUL;
			end
			pcs_pkg::S_LCG_MUL: begin
				mul_a = noise_q;
				mul_b = pcs_pkg::LCG_MUL;
			end
			pcs_pkg::S_JF_MUL: begin
				mul_a = {11'd0, jk};
				mul_b = {8'd0, rmag_q};
			end
			pcs_pkg::S_JD_MUL: begin
				mul_a = jbase;
				mul_b = prod_q[54:23];
			end
			pcs_pkg::S_NT_MUL: begin
				mul_a = {8'd0, rmag_q};
				mul_b = {8'd0, nenv_q};
			end
			pcs_pkg::S_BT_MUL: begin
				mul_a = {17'd0, sine_mag_q};
				mul_b = {8'd0, renv_q};
			end
			pcs_pkg::S_NM_MUL: begin
				mul_a = {16'd0, cfg.noise_mix};
				mul_b = {8'd0, nterm_q};
			end
			pcs_pkg::S_BM_MUL: begin
				mul_a = {16'd0, cfg.body_mix};
				mul_b = {8'd0, bterm_q};
			end
			pcs_pkg::S_G_MUL: begin
				mul_a = {15'd0, gain_q};
				mul_b = {7'd0, mixmag_q};
			end
			pcs_pkg::S_NE_MUL: begin
				mul_a = {8'd0, nenv_q};
				mul_b = {8'd0, cfg.noise_rate};
			end
			pcs_pkg::S_RE_MUL: begin
				mul_a = {8'd0, renv_q};
				mul_b = {8'd0, decay_q};
			end
			default: ;
		endcase
	end

	// sequencer and voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcs_pkg::S_IDLE;
			jsel_q <= pcs_pkg::J_VOL;
			noise_q <= '0;
			phase_q <= '0;
			count_q <= '0;
			nenv_q <= '0;
			renv_q <= '0;
			gain_q <= '0;
			step_q <= '0;
			decay_q <= '0;
			sounding_q <= 1'b0;
		end else begin
			case (state_q)
				pcs_pkg::S_IDLE: begin
					if (accept_in) begin
						state_q <= kind ? pcs_pkg::S_SEED_ADD : pcs_pkg::S_CHECK;
					end
				end
				pcs_pkg::S_SEED_ADD: begin
					noise_q <= prod_q[31:0] + pcs_pkg::SCRAMBLE_ADD;
					jsel_q <= pcs_pkg::J_VOL;
					state_q <= pcs_pkg::S_LCG_MUL;
				end
				pcs_pkg::S_LCG_MUL: begin
					state_q <= pcs_pkg::S_LCG_ADD;
				end
				pcs_pkg::S_LCG_ADD: begin
					noise_q <= noise_next;
					state_q <= pcs_pkg::S_RMAG;
				end
				pcs_pkg::S_RMAG: begin
					state_q <= (jsel_q == pcs_pkg::J_NOISE) ? pcs_pkg::S_NT_MUL :
						pcs_pkg::S_JF_MUL;
				end
				pcs_pkg::S_JF_MUL: begin
					state_q <= pcs_pkg::S_JD_MUL;
				end
				pcs_pkg::S_JD_MUL: begin
					state_q <= pcs_pkg::S_JAPPLY;
				end
				pcs_pkg::S_JAPPLY: begin
					case (jsel_q)
						pcs_pkg::J_VOL: begin
							gain_q <= jsum[16:0];
							jsel_q <= pcs_pkg::J_PING;
							state_q <= pcs_pkg::S_LCG_MUL;
						end
						pcs_pkg::J_PING: begin
							step_q <= jsum[31:0];
							jsel_q <= pcs_pkg::J_RING;
							state_q <= pcs_pkg::S_LCG_MUL;
						end
						default: begin
							// jittered decay saturates at full scale
							decay_q <= (jsum[32:24] != 9'd0) ? 24'hFFFFFF : jsum[23:0];
							state_q <= pcs_pkg::S_START;
						end
					endcase
				end
				pcs_pkg::S_START: begin
					phase_q <= '0;
					count_q <= '0;
					nenv_q <= pcs_pkg::ENV_ONE;
					renv_q <= pcs_pkg::ENV_ONE;
					sounding_q <= 1'b1;
					state_q <= pcs_pkg::S_CHECK;
				end
				pcs_pkg::S_CHECK: begin
					// also ends a click whose length was cut below the count
					if (sounding_q && count_q < cfg.click_length) begin
						jsel_q <= pcs_pkg::J_NOISE;
						state_q <= pcs_pkg::S_LCG_MUL;
					end else begin
						sounding_q <= 1'b0;
						state_q <= pcs_pkg::S_EMIT;
					end
				end
				pcs_pkg::S_NT_MUL: state_q <= pcs_pkg::S_BT_MUL;
				pcs_pkg::S_BT_MUL: state_q <= pcs_pkg::S_NM_MUL;
				pcs_pkg::S_NM_MUL: state_q <= pcs_pkg::S_BM_MUL;
				pcs_pkg::S_BM_MUL: state_q <= pcs_pkg::S_MIX;
				pcs_pkg::S_MIX:    state_q <= pcs_pkg::S_MABS;
				pcs_pkg::S_MABS:   state_q <= pcs_pkg::S_G_MUL;
				pcs_pkg::S_G_MUL:  state_q <= pcs_pkg::S_SAT;
				pcs_pkg::S_SAT:    state_q <= pcs_pkg::S_NE_MUL;
				pcs_pkg::S_NE_MUL: state_q <= pcs_pkg::S_RE_MUL;
				pcs_pkg::S_RE_MUL: begin
					nenv_q <= nenv_q - prod_q[47:24];
					state_q <= pcs_pkg::S_UPD;
				end
				pcs_pkg::S_UPD: begin
					renv_q <= renv_q - prod_q[47:24];
					phase_q <= phase_q + step_q;
					count_q <= count_inc;
					if (count_inc >= cfg.click_length) begin
						sounding_q <= 1'b0;
					end
					state_q <= pcs_pkg::S_EMIT;
				end
				pcs_pkg::S_EMIT: begin
					if (out_free) begin
						state_q <= pcs_pkg::S_IDLE;
					end
				end
				default: state_q <= pcs_pkg::S_IDLE;
			endcase
		end
	end

	// working registers, sign-magnitude so every divide truncates toward zero
	always_ff @(posedge clk) begin
		case (state_q)
			pcs_pkg::S_RMAG: begin
				rmag_q <= rmag_next;
				rneg_q <= !noise_q[31];
				sine_mag_q <= sine_val[14:0];
				sine_neg_q <= phase_q[31];
			end
			pcs_pkg::S_CHECK: begin
				res_sample_q <= '0;
				res_active_q <= 1'b0;
			end
			pcs_pkg::S_BT_MUL: nterm_q <= prod_q[46:23];
			pcs_pkg::S_NM_MUL: bterm_q <= prod_q[38:15];
			pcs_pkg::S_BM_MUL: p1_q <= prod_q[39:0];
			pcs_pkg::S_MIX:    sum_q <= t1 + t2;
			pcs_pkg::S_MABS: begin
				mixmag_q <= sum_abs[40:16];
				mixneg_q <= sum_q[41];
			end
			pcs_pkg::S_SAT: begin
				res_sample_q <= sat_val;
				res_active_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pcs_pkg::S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pcs_pkg::S_EMIT && out_free) begin
			sample_q <= res_sample_q;
			active_q <= res_active_q;
		end
	end

	a_env_live: assert property (@(posedge clk) disable iff (!arst_n)
		sounding_q |-> (nenv_q != 24'd0 && renv_q != 24'd0))
		else $error("envelope reached zero during a click");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !active) |-> (sample == 16'sd0))
		else $error("inactive beat carries a nonzero sample");

	a_beat_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> (state_q != pcs_pkg::S_IDLE))
		else $error("accepted beat did not start the sequencer");

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == pcs_pkg::S_EMIT))
		else $error("result appeared outside the emit step");

endmodule

FILE: tb/percussive_click_synth_tb.sv
`timescale 1ns / 1ps

module percussive_click_synth_tb;

	localparam int TAB_BITS = pcs_pkg::SINE_TABLE_BITS;
	localparam int TAB_N = 1 << TAB_BITS;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint UNIT_Q30 = 64'sd1073741824;
	localparam longint UNIT_ENV = 64'sd8388608;
	localparam logic [31:0] SEED_MUL = 32'd2654435761;
	localparam logic [31:0] SEED_INC = 32'd12345;
	localparam logic [31:0] NOISE_MUL = 32'd1664525;
	localparam logic [31:0] NOISE_INC = 32'd1013904223;
	localparam longint DEPTH_VOL = 64'sd1342177;
	localparam longint DEPTH_PING = 64'sd503316;
	localparam longint DEPTH_RING = 64'sd1006633;

	localparam logic BEAT_TICK = 1'b0;
	localparam logic BEAT_STRIKE = 1'b1;
	// index past the last register, must be ignored
	localparam logic [pcs_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES = 8;
	localparam int PHASE_BEATS = 48;

	class click_sample_board;
		typedef struct {
			logic signed [15:0] sample;
			logic active;
		} click_out_t;

		click_out_t expected_samples[$];
		int errors;

		longint click_len, ping_base, ring_base, noise_decay;
		longint vol_base, noise_wt, body_wt;

		logic [31:0] noise_reg, phase, step_now;
		longint count, noise_env, ring_env, gain_now, decay_now;
		bit sounding;
		longint sine_quarter[0:TAB_N];

		function new();
			longint x, x2, term, sum, v;
			for (int i = 0; i <= TAB_N; i++) begin
				x = (HALF_PI_Q30 * longint'(i)) / longint'(TAB_N);
				x2 = (x * x) / UNIT_Q30;
				term = x;
				sum = x;
				for (int n = 1; n <= 8; n++) begin
					term = -((term * x2) / UNIT_Q30) / longint'((2 * n) * (2 * n + 1));
					sum = sum + term;
				end
				if (sum < 0) begin
					sum = 0;
				end
				v = (sum * 32767 + (UNIT_Q30 / 2)) / UNIT_Q30;
				if (v > 32767) begin
					v = 32767;
				end
				sine_quarter[i] = v;
			end
			click_len = 2640;
			ping_base = 62634940;
			ring_base = 62915;
			noise_decay = 139231;
			vol_base = 19661;
			noise_wt = 45875;
			body_wt = 39322;
			noise_reg = '0;
			phase = '0;
			step_now = '0;
			count = 0;
			noise_env = 0;
			ring_env = 0;
			gain_now = 0;
			decay_now = 0;
			sounding = 1'b0;
			errors = 0;
		endfunction

		function void load_reg(logic [pcs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				pcs_pkg::REG_CLICK_LENGTH: click_len = val[15:0];
				pcs_pkg::REG_PING_STEP:    ping_base = val;
				pcs_pkg::REG_RING_RATE:    ring_base = val[23:0];
				pcs_pkg::REG_NOISE_RATE:   noise_decay = val[23:0];
				pcs_pkg::REG_VOLUME:       vol_base = val[15:0];
				pcs_pkg::REG_NOISE_MIX:    noise_wt = val[15:0];
				pcs_pkg::REG_BODY_MIX:     body_wt = val[15:0];
				default: ;
			endcase
		endfunction

		function longint draw_noise();
			longint r;
			noise_reg = noise_reg * NOISE_MUL + NOISE_INC;
			r = noise_reg[31:8];
			return r - UNIT_ENV;
		endfunction

		function longint jitter_delta(longint base, longint depth, longint r);
			longint mag;
			mag = (r < 0) ? -r : r;
			return (base * ((depth * mag) >>> 23)) >>> 24;
		endfunction

		function longint sine_lookup(logic [31:0] ph);
			int idx;
			longint v;
			idx = int'((ph >> (30 - TAB_BITS)) & (TAB_N - 1));
			v = ph[30] ? sine_quarter[TAB_N - idx] : sine_quarter[idx];
			return ph[31] ? -v : v;
		endfunction

		function void note_beat(logic strike, logic [31:0] seed);
			click_out_t res;
			longint r_vol, r_ping, r_ring, d, tmp, nz, nterm, bterm, mix, s;
			res.sample = '0;
			res.active = 1'b0;
			if (strike) begin
				noise_reg = seed * SEED_MUL + SEED_INC;
				r_vol = draw_noise();
				r_ping = draw_noise();
				r_ring = draw_noise();
				d = jitter_delta(vol_base, DEPTH_VOL, r_vol);
				gain_now = (r_vol < 0) ? vol_base - d : vol_base + d;
				d = jitter_delta(ping_base, DEPTH_PING, r_ping);
				tmp = (r_ping < 0) ? ping_base - d : ping_base + d;
				step_now = tmp[31:0];
				d = jitter_delta(ring_base, DEPTH_RING, r_ring);
				tmp = (r_ring < 0) ? ring_base - d : ring_base + d;
				decay_now = (tmp > 64'sh00FF_FFFF) ? 64'sh00FF_FFFF : tmp;
				phase = '0;
				count = 0;
				noise_env = UNIT_ENV;
				ring_env = UNIT_ENV;
				sounding = 1'b1;
			end
			if (sounding && count >= click_len) begin
				sounding = 1'b0;
			end
			if (sounding) begin
				nz = draw_noise();
				nterm = (nz * noise_env) / UNIT_ENV;
				bterm = (sine_lookup(phase) * ring_env) / 64'sd32768;
				mix = (noise_wt * nterm + body_wt * bterm) / 64'sd65536;
				s = (gain_now * mix) / 64'sd16777216;
				if (s > 32767) begin
					s = 32767;
				end
				if (s < -32768) begin
					s = -32768;
				end
				res.sample = s[15:0];
				res.active = 1'b1;
				noise_env = noise_env - ((noise_env * noise_decay) >>> 24);
				ring_env = ring_env - ((ring_env * decay_now) >>> 24);
				phase = phase + step_now;
				count = (count + 1) & 64'hFFFF;
				if (count >= click_len) begin
					sounding = 1'b0;
				end
			end
			expected_samples = {expected_samples, res};
		endfunction

		function void check_sample(logic signed [15:0] got_sample, logic got_active);
			click_out_t want;
			if (expected_samples.size() == 0) begin
				$error("sample beat with nothing expected: sample %0d active %0b",
					got_sample, got_active);
				errors++;
				return;
			end
			want = expected_samples.pop_front();
			if (got_sample !== want.sample) begin
				$error("sample mismatch: expected %0d, actual %0d", want.sample, got_sample);
				errors++;
			end
			if (got_active !== want.active) begin
				$error("active mismatch: expected %0b, actual %0b", want.active, got_active);
				errors++;
			end
		endfunction

		function int waiting();
			return expected_samples.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [31:0] seed = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] sample;
	logic active;
	logic cfg_wen = 1'b0;
	logic [pcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	click_sample_board board;
	bit sender_calm = 1'b0;
	bit hold_off_req = 1'b0;
	int strike_odds = 10;
	int idle_cycles = 0;

	percussive_click_synth uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.seed(seed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample(sample),
		.active(active),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// zero, all ones, a narrow value, or raw bits with junk above the width
	function automatic logic [31:0] pick_value(input int bits);
		logic [31:0] mask;
		mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return mask;
			2, 3: return $urandom() & (mask >> (bits / 3));
			default: return $urandom();
		endcase
	endfunction

	task automatic write_reg(input logic [pcs_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		board.load_reg(idx, val);
	endtask

	task automatic send_beat(input logic strike, input logic [31:0] s);
		int gap;
		gap = sender_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind = strike;
		seed = s;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_beat(strike, s);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (board.waiting() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_settings();
		int pick;
		logic [31:0] len;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			len = 1;
		end else if (pick == 1) begin
			len = $urandom_range(100, 400);
		end else begin
			len = $urandom_range(2, 30);
		end
		write_reg(pcs_pkg::REG_CLICK_LENGTH, len | ($urandom() & 32'hFFFF_0000));
		write_reg(pcs_pkg::REG_PING_STEP, pick_value(32));
		write_reg(pcs_pkg::REG_RING_RATE, pick_value(24));
		write_reg(pcs_pkg::REG_NOISE_RATE, pick_value(24));
		write_reg(pcs_pkg::REG_VOLUME, pick_value(16));
		write_reg(pcs_pkg::REG_NOISE_MIX, pick_value(16));
		write_reg(pcs_pkg::REG_BODY_MIX, pick_value(16));
		// strike about once per click so most ticks land inside one
		strike_odds = (len < 40) ? len + 1 : 25;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				board.check_sample(sample, active);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// receiver: bursts of ready, random stalls, one long hold-off on request
	initial begin
		int run;
		wait (arst_n);
		forever begin
			if (hold_off_req) begin
				out_stall = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				out_stall = 1'b0;
				repeat ($urandom_range(1, 24)) @(negedge clk);
				run = pick_gap();
				if (run > 0) begin
					out_stall = 1'b1;
					repeat (run) @(negedge clk);
				end
			end
		end
	end

	initial begin
		board = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(REG_NONE, 32'hFFFF_FFFF);
		send_beat(BEAT_TICK, $urandom());
		send_beat(BEAT_STRIKE, 32'h0000_0000);
		send_beat(BEAT_TICK, $urandom());
		send_beat(BEAT_TICK, $urandom());
		send_beat(BEAT_STRIKE, 32'hFFFF_FFFF);
		send_beat(BEAT_TICK, $urandom());
		drain();

		// loud three-sample click on quarter-turn steps, no decay, saturates
		write_reg(pcs_pkg::REG_CLICK_LENGTH, 32'd3);
		write_reg(pcs_pkg::REG_PING_STEP, 32'h4000_0000);
		write_reg(pcs_pkg::REG_RING_RATE, 32'd0);
		write_reg(pcs_pkg::REG_NOISE_RATE, 32'd0);
		write_reg(pcs_pkg::REG_VOLUME, 32'hFFFF);
		write_reg(pcs_pkg::REG_NOISE_MIX, 32'hFFFF);
		write_reg(pcs_pkg::REG_BODY_MIX, 32'hFFFF);
		send_beat(BEAT_STRIKE, 32'h1234_5678);
		repeat (4) send_beat(BEAT_TICK, $urandom());
		drain();

		// zero length: strike draws jitter but stays silent
		write_reg(pcs_pkg::REG_CLICK_LENGTH, 32'd0);
		send_beat(BEAT_STRIKE, $urandom());
		send_beat(BEAT_TICK, $urandom());
		drain();

		// step wraps, decay saturates, restrike inside a click
		write_reg(pcs_pkg::REG_CLICK_LENGTH, 32'hFFFF);
		write_reg(pcs_pkg::REG_PING_STEP, 32'hFFFF_FFFF);
		write_reg(pcs_pkg::REG_RING_RATE, 32'h00FF_FFFF);
		write_reg(pcs_pkg::REG_NOISE_RATE, 32'h00FF_FFFF);
		write_reg(pcs_pkg::REG_NOISE_MIX, 32'd0);
		send_beat(BEAT_STRIKE, 32'hA5A5_5A5A);
		send_beat(BEAT_TICK, $urandom());
		send_beat(BEAT_STRIKE, 32'h0F0F_F0F0);
		send_beat(BEAT_TICK, $urandom());
		send_beat(BEAT_STRIKE, 32'h8000_0001);
		send_beat(BEAT_TICK, $urandom());
		send_beat(BEAT_TICK, $urandom());
		drain();

		// shorten the length below the running count, click ends at once
		write_reg(pcs_pkg::REG_CLICK_LENGTH, 32'd2);
		send_beat(BEAT_TICK, $urandom());
		send_beat(BEAT_TICK, $urandom());
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				write_reg(pcs_pkg::REG_CLICK_LENGTH, 32'd2640);
				write_reg(pcs_pkg::REG_PING_STEP, 32'd62634940);
				write_reg(pcs_pkg::REG_RING_RATE, 32'd62915);
				write_reg(pcs_pkg::REG_NOISE_RATE, 32'd139231);
				write_reg(pcs_pkg::REG_VOLUME, 32'd19661);
				write_reg(pcs_pkg::REG_NOISE_MIX, 32'd45875);
				write_reg(pcs_pkg::REG_BODY_MIX, 32'd39322);
				strike_odds = 25;
			end else begin
				random_settings();
			end
			sender_calm = (p % 3 == 2);
			if (p == 1) begin
				hold_off_req = 1'b1;
			end
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if ($urandom_range(0, strike_odds) == 0) begin
					send_beat(BEAT_STRIKE, $urandom());
				end else begin
					send_beat(BEAT_TICK, $urandom());
				end
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.waiting() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: percussive_click_synth.f
sv/pcs_pkg.sv
sv/pcs_mul.sv
sv/pcs_cfg.sv
sv/percussive_click_synth.sv
tb/percussive_click_synth_tb.sv
